### hdl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types for the sorted list insert block
// Result kinds, opcodes, controller states and the control group sent to each cell.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_INSERTED = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_ELEMENT  = 2'd2,
      KIND_EMPTY    = 2'd3
   } kind_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DUMP   = 1'b1
   } opcode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic                     insert;
      logic                     rotate;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

### hdl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Holds one value and its valid bit. On insert it either keeps its value,
// takes the new value, or takes its lower neighbor's value. On rotate it
// takes its upper neighbor's value, or the head value if it is the tail.
// ----------------------------------------------------------------------------
module sli_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  sli_pkg::cell_ctrl_type              ctrl,
   input  logic signed [sli_pkg::DATA_W-1:0]   head_value,
   input  logic signed [sli_pkg::DATA_W-1:0]   prev_value,
   input  logic                                prev_valid,
   input  logic                                prev_match,
   input  logic signed [sli_pkg::DATA_W-1:0]   next_value,
   input  logic                                next_valid,
   output logic signed [sli_pkg::DATA_W-1:0]   value,
   output logic                                valid,
   output logic                                match
);

   logic signed [sli_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              valid_ff, valid_in;

   // An empty slot counts as a match, so the insert point is the first
   // slot that is empty or holds a value not smaller than the new one.
   assign match = !valid_ff || (value_ff >= ctrl.value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.insert && match) begin
         if (prev_match) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else begin
            value_in = ctrl.value;
            valid_in = 1'b1;
         end
      end else if (ctrl.rotate && valid_ff) begin
         value_in = next_valid ? next_value : head_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

### hdl/sorted_list_insert.sv
// ----------------------------------------------------------------------------
// sorted_list_insert: ascending list of signed values in a chain of cells
// Keeps up to CAPACITY values sorted; inserts new values and dumps in order.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one beat per command. req_tuser is the opcode:
// insert places req_tdata in front of the first stored value that is not
// smaller; dump streams the whole list. The response channel returns the
// result beats: rsp_tuser is the result kind, rsp_tdata the stored value for
// dumped elements (zero otherwise), and rsp_tlast marks the final beat of a
// command.
// On an insert every cell compares its value with the new one at once and
// the cells at and above the insert point shift up by one. Its response
// appears in the cycle after the request beat, and back-to-back inserts
// are taken at one per cycle while the response register drains.
// A dump of N values first enters the dump state, then sends one beat per
// cycle while the receiver takes them. The chain rotates toward the head on
// each beat so that the head cell always shows the next value; after N
// beats the list is back in place. No request is taken during a dump. A full
// list answers an insert with a "full" beat and drops the value; an empty
// list answers a dump with one "empty" beat.
// Reset clears every valid bit and the entry count. When the receiver stalls,
// the response beat holds and the block stops taking requests or rotating.
// ----------------------------------------------------------------------------
module sorted_list_insert #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] new_value
   input  logic        req_tuser,   // [0] opcode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   // Wide enough to hold the count itself, which reaches CAPACITY.
   localparam int CW = $clog2(CAPACITY + 1);

   // Chain wiring.
   logic signed [sli_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic                              cell_valid [CAPACITY];
   logic                              cell_match [CAPACITY];
   sli_pkg::cell_ctrl_type            ctrl;

   // Controller state.
   sli_pkg::state_type                state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   sli_pkg::kind_type                 kind_ff, kind_in;
   logic [sli_pkg::DATA_W-1:0]        data_ff, data_in;
   logic                              last_ff, last_in;

   logic                              out_free;
   logic                              req_fire;
   logic                              is_full;
   logic                              is_final;

   // ------------------------------------------------------------------------
   // Cell chain. Each cell sees its lower neighbor for the insert shift and
   // its upper neighbor for the dump rotation; the head value is broadcast
   // so the tail can close the ring.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [sli_pkg::DATA_W-1:0] p_value, n_value;
      logic                              p_valid, p_match, n_valid;

      if (i == 0) begin : g_first
         assign p_value = '0;
         assign p_valid = 1'b0;
         assign p_match = 1'b0;
      end else begin : g_mid
         assign p_value = cell_value[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_match = cell_match[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign n_value = '0;
         assign n_valid = 1'b0;
      end else begin : g_inner
         assign n_value = cell_value[i+1];
         assign n_valid = cell_valid[i+1];
      end

      sli_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .head_value (cell_value[0]),
         .prev_value (p_value),
         .prev_valid (p_valid),
         .prev_match (p_match),
         .next_value (n_value),
         .next_valid (n_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .match      (cell_match[i])
      );
   end

   // ------------------------------------------------------------------------
   // Controller.
   // ------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_final = (CW'(idx_ff + 1'b1) == count_ff);
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      kind_in      = kind_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      req_tready   = 1'b0;
      ctrl.insert  = 1'b0;
      ctrl.rotate  = 1'b0;
      ctrl.value   = req_tdata;

      unique case (state_ff)
         sli_pkg::ST_IDLE: begin
            req_tready = out_free;
            if (req_fire) begin
               if (req_tuser == sli_pkg::OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  data_in      = '0;
                  last_in      = 1'b1;
                  if (is_full) begin
                     kind_in = sli_pkg::KIND_FULL;
                  end else begin
                     kind_in     = sli_pkg::KIND_INSERTED;
                     ctrl.insert = 1'b1;
                     count_in    = CW'(count_ff + 1'b1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = sli_pkg::KIND_EMPTY;
                  data_in      = '0;
                  last_in      = 1'b1;
               end else begin
                  state_in = sli_pkg::ST_DUMP;
                  idx_in   = '0;
               end
            end
         end
         sli_pkg::ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = sli_pkg::KIND_ELEMENT;
               data_in      = cell_value[0];
               last_in      = is_final;
               ctrl.rotate  = 1'b1;
               idx_in       = CW'(idx_ff + 1'b1);
               if (is_final) begin
                  state_in = sli_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sli_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      if (reset) begin
         state_ff     <= sli_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The entry count never passes the number of cells.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // A dump is only in progress over a non-empty list, and takes no requests.
   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sli_pkg::ST_DUMP) |-> (count_ff != '0) && !req_tready)
      else $error("dump running over an empty list or taking requests");

   // Non-element results carry zero data and close their command.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff != sli_pkg::KIND_ELEMENT) |-> last_ff && (data_ff == '0))
      else $error("single-beat response malformed");

   // An accepted insert into a non-full list adds exactly one entry.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == sli_pkg::OP_INSERT) && !is_full
      |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not grow the list by one");

endmodule
